/* hdl/sbrs_pkg.sv */
// sbrs_pkg: shared types and fixed constants of the servo bus register slave
// no dependencies; imported by sbrs_regfile, servo_bus_register_slave_core, sbrs_status_checker and the testbench

package sbrs_pkg;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_HDR    = 5'b00010,
      S_DATA   = 5'b00100,
      S_SUM    = 5'b01000,
      S_COMMIT = 5'b10000
   } seq_state_type;

   // request kinds carried in req_tuser
   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // csr register indexes
   localparam logic [1:0] CSR_DEVICE_ID   = 2'd0;
   localparam logic [1:0] CSR_MODEL_LOW   = 2'd1;
   localparam logic [1:0] CSR_MODEL_HIGH  = 2'd2;
   localparam logic [1:0] CSR_FW_VERSION  = 2'd3;

   // read-only table addresses
   localparam int ADDR_MODEL_LOW  = 0;
   localparam int ADDR_MODEL_HIGH = 1;
   localparam int ADDR_FW_VERSION = 2;
   localparam int ADDR_DEVICE_ID  = 3;

   // packet framing
   localparam logic [7:0] SYNC_BYTE       = 8'hff;
   localparam logic [7:0] STATUS_BASE_LEN = 8'd2;
   localparam logic [7:0] NO_ERROR        = 8'd0;

   // header byte positions
   localparam logic [2:0] HDR_SYNC0 = 3'd0;
   localparam logic [2:0] HDR_SYNC1 = 3'd1;
   localparam logic [2:0] HDR_ID    = 3'd2;
   localparam logic [2:0] HDR_LEN   = 3'd3;
   localparam logic [2:0] HDR_ERR   = 3'd4;

   // bounded writable entries (timeouts) and their legal range
   localparam int         BOUNDED_COUNT = 3;
   localparam logic [7:0] BOUND_LO      = 8'd10;
   localparam logic [7:0] BOUND_HI      = 8'd254;

   // reset value of device id
   localparam logic [7:0] DEVICE_ID_RESET = 8'd253;

endpackage

/* hdl/sbrs_regfile.sv */
// sbrs_regfile: writable register table, one write and one registered read port
// entries not yet written read as their reset defaults; uses sbrs_pkg

module sbrs_regfile
   import sbrs_pkg::*;
#(
   parameter int DEPTH          = 12,
   parameter int DFLT_LINK      = 0,
   parameter int DFLT_SEND      = 0,
   parameter int DFLT_RECEIVE   = 0,
   localparam int MEM_DEPTH     = (DEPTH > 0) ? DEPTH : 1,
   localparam int OFF_W         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [OFF_W-1:0] wr_off,
   input  logic [7:0]       wr_data,
   input  logic [OFF_W-1:0] rd_off,
   output logic [7:0]       rd_data
);

   logic [7:0]           mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff;
   logic [7:0]           rd_data_ff;

   // reset value of an entry
   function automatic logic [7:0] dflt(input logic [OFF_W-1:0] off);
      logic [7:0] v;
      v = 8'd0;
      if (int'(off) == 0) begin
         v = 8'(DFLT_LINK);
      end else if (int'(off) == 1) begin
         v = 8'(DFLT_SEND);
      end else if (int'(off) == 2) begin
         v = 8'(DFLT_RECEIVE);
      end
      return v;
   endfunction

   // storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_off] <= wr_data;
      end
   end

   // per-entry written marks
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_off] <= 1'b1;
      end
   end

   // registered read with default substitution
   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[rd_off] ? mem[rd_off] : dflt(rd_off);
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/servo_bus_register_slave_core.sv */
// servo_bus_register_slave_core: register table of a servo bus adapter
// answers reads and staged writes with status packets; uses sbrs_pkg, sbrs_regfile
//
//   channel | direction | ports                  | payload
//   req     | in        | req_tvalid/tready      | tuser action; tdata start, count, data
//   rsp     | out       | rsp_tvalid/tready      | tdata status byte; tlast on checksum
//   csr     | in        | csr_wr_en              | csr_index, csr_wdata
//
// a read of n bytes answers a (6 + n)-byte packet, one packet byte per cycle while rsp
// does not stall, from the sequencer through the output register, data bytes fetched from the
// csr registers or the table ram. a write byte that is not the last is only staged; the last
// one answers a 6-byte status, preceded by a copy pass of the count bytes from the staging ram when the write is good.
// req_tready is high only while the sequencer is idle; a stalled rsp holds the
// sequencer. reset is synchronous; the table needs no clearing pass.

module servo_bus_register_slave_core
   import sbrs_pkg::*;
#(
   parameter int REG_COUNT               = 16,
   parameter int FIRST_WRITABLE          = 4,
   parameter int RANGE_ERROR_CODE        = 8,
   parameter int DEFAULT_LINK_TIMEOUT    = 0,
   parameter int DEFAULT_SEND_TIMEOUT    = 0,
   parameter int DEFAULT_RECEIVE_TIMEOUT = 0
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // start_addr [7:0], count [15:8], data_byte [23:16]
   input  logic        req_tuser,   // action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int AW        = $clog2(REG_COUNT);
   localparam int CW        = $clog2(REG_COUNT + 1);
   localparam int DEPTH     = REG_COUNT - FIRST_WRITABLE;
   localparam int MEM_DEPTH = (DEPTH > 0) ? DEPTH : 1;
   localparam int OFF_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // configuration registers
   logic [7:0] device_id_ff, model_low_ff, model_high_ff, fw_version_ff;

   // sequencer
   seq_state_type    state_ff, state_in;
   logic [2:0]       hcnt_ff, hcnt_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       err_ff, err_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;

   // write framing
   logic [7:0]       br_ff, br_in;
   logic [7:0]       waddr_ff, waddr_in;
   logic [7:0]       wtotal_ff, wtotal_in;
   logic             bad_ff, bad_in;

   // commit pass
   logic [OFF_W-1:0] coff_ff, coff_in;
   logic [CW-1:0]    ccnt_ff, ccnt_in;
   logic             pend_ff, pend_in;
   logic [OFF_W-1:0] pend_off_ff;
   logic [7:0]       stq_ff;
   logic [7:0]       stage_mem [MEM_DEPTH];

   // output register
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]       rsp_tdata_ff;
   logic             rsp_tlast_ff;

   // request fields and decode
   logic [7:0]       f_start, f_count, f_data;
   logic             req_fire, rd_err, first, w_done, w_ok, in_tab, byte_bad, bad_acc;
   logic             stg_we;
   logic [7:0]       wa_base, tot, br_next;
   logic [8:0]       wa;
   logic [OFF_W-1:0] stg_off;

   // emit path
   logic             out_free, emit, add_en;
   logic [7:0]       byte_sel, data_val, rd_data;
   logic [AW-1:0]    rd_addr;
   logic [OFF_W-1:0] rd_off;

   assign f_start  = req_tdata[7:0];
   assign f_count  = req_tdata[15:8];
   assign f_data   = req_tdata[23:16];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;

   // read range check
   assign rd_err = (f_count == 8'd0) ||
                   (({1'b0, f_start} + {1'b0, f_count}) > 9'(REG_COUNT));

   // write byte placement and bounds
   assign first    = (br_ff == 8'd0);
   assign wa_base  = first ? f_start : waddr_ff;
   assign tot      = first ? f_count : wtotal_ff;
   assign wa       = {1'b0, wa_base} + {1'b0, br_ff};
   assign in_tab   = (wa >= 9'(FIRST_WRITABLE)) && (wa < 9'(REG_COUNT));
   assign stg_off  = OFF_W'(wa - 9'(FIRST_WRITABLE));
   assign byte_bad = in_tab && (wa < 9'(FIRST_WRITABLE + BOUNDED_COUNT)) &&
                     ((f_data < BOUND_LO) || (f_data > BOUND_HI));
   assign bad_acc  = (first ? 1'b0 : bad_ff) | byte_bad;
   assign br_next  = br_ff + 8'd1;
   assign w_done   = !(br_next < tot);
   assign w_ok     = (wa_base >= 8'(FIRST_WRITABLE)) &&
                     (({1'b0, wa_base} + {1'b0, tot}) <= 9'(REG_COUNT)) && !bad_acc;
   assign stg_we   = req_fire && (req_tuser == ACTION_WRITE) &&
                     !(first && f_count == 8'd0) && in_tab;

   // byte of the table at idx
   always_comb begin
      data_val = rd_data;
      if (int'(idx_ff) < FIRST_WRITABLE) begin
         if (int'(idx_ff) == ADDR_MODEL_LOW) begin
            data_val = model_low_ff;
         end else if (int'(idx_ff) == ADDR_MODEL_HIGH) begin
            data_val = model_high_ff;
         end else if (int'(idx_ff) == ADDR_FW_VERSION) begin
            data_val = fw_version_ff;
         end else if (int'(idx_ff) == ADDR_DEVICE_ID) begin
            data_val = device_id_ff;
         end else begin
            data_val = 8'd0;
         end
      end
   end

   // packet byte selection and checksum adder
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign emit     = out_free &&
                     (state_ff == S_HDR || state_ff == S_DATA || state_ff == S_SUM);

   always_comb begin
      byte_sel = ~sum_ff;
      add_en   = 1'b0;
      unique case (state_ff)
         S_HDR: begin
            case (hcnt_ff)
               HDR_SYNC0, HDR_SYNC1: byte_sel = SYNC_BYTE;
               HDR_ID:               byte_sel = device_id_ff;
               HDR_LEN:              byte_sel = len_ff;
               default:              byte_sel = err_ff;
            endcase
            add_en = emit && (hcnt_ff >= HDR_ID);
         end
         S_DATA: begin
            byte_sel = data_val;
            add_en   = emit;
         end
         S_IDLE, S_SUM, S_COMMIT: byte_sel = ~sum_ff;
         default: byte_sel = ~sum_ff;
      endcase
   end

   // table read address runs one beat ahead while data streams
   assign rd_addr = (state_ff == S_DATA && emit) ? idx_ff + AW'(1) : idx_ff;
   assign rd_off  = OFF_W'({1'b0, rd_addr} - (AW + 1)'(FIRST_WRITABLE));

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      hcnt_in   = hcnt_ff;
      len_in    = len_ff;
      err_in    = err_ff;
      n_in      = n_ff;
      idx_in    = idx_ff;
      sum_in    = add_en ? sum_ff + byte_sel : sum_ff;
      br_in     = br_ff;
      waddr_in  = waddr_ff;
      wtotal_in = wtotal_ff;
      bad_in    = bad_ff;
      coff_in   = coff_ff;
      ccnt_in   = ccnt_ff;
      pend_in   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               hcnt_in  = HDR_SYNC0;
               sum_in   = 8'd0;
               n_in     = '0;
               len_in   = STATUS_BASE_LEN;
               err_in   = 8'(RANGE_ERROR_CODE);
               if (req_tuser == ACTION_READ) begin
                  state_in = S_HDR;
                  idx_in   = AW'(f_start);
                  if (!rd_err) begin
                     n_in   = CW'(f_count);
                     len_in = STATUS_BASE_LEN + f_count;
                     err_in = NO_ERROR;
                  end
               end else begin
                  if (first) begin
                     waddr_in  = f_start;
                     wtotal_in = f_count;
                  end
                  if (first && f_count == 8'd0) begin
                     // empty write: range error, nothing staged
                     state_in = S_HDR;
                  end else begin
                     bad_in = bad_acc;
                     if (!w_done) begin
                        br_in = br_next;
                     end else begin
                        br_in = 8'd0;
                        if (w_ok) begin
                           state_in = S_COMMIT;
                           coff_in  = OFF_W'({1'b0, wa_base} - 9'(FIRST_WRITABLE));
                           ccnt_in  = CW'(tot);
                           err_in   = NO_ERROR;
                        end else begin
                           state_in = S_HDR;
                        end
                     end
                  end
               end
            end
         end
         S_COMMIT: begin
            pend_in = 1'b1;
            coff_in = coff_ff + OFF_W'(1);
            ccnt_in = ccnt_ff - CW'(1);
            if (ccnt_ff == CW'(1)) begin
               state_in = S_HDR;
            end
         end
         S_HDR: begin
            if (emit) begin
               hcnt_in = hcnt_ff + 3'd1;
               if (hcnt_ff == HDR_ERR) begin
                  state_in = (n_ff != '0) ? S_DATA : S_SUM;
               end
            end
         end
         S_DATA: begin
            if (emit) begin
               idx_in = idx_ff + AW'(1);
               n_in   = n_ff - CW'(1);
               if (n_ff == CW'(1)) begin
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (emit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         br_ff         <= 8'd0;
         waddr_ff      <= 8'd0;
         wtotal_ff     <= 8'd0;
         bad_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         hcnt_ff       <= HDR_SYNC0;
         n_ff          <= '0;
         ccnt_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         br_ff         <= br_in;
         waddr_ff      <= waddr_in;
         wtotal_ff     <= wtotal_in;
         bad_ff        <= bad_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         hcnt_ff       <= hcnt_in;
         n_ff          <= n_in;
         ccnt_ff       <= ccnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      err_ff      <= err_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      coff_ff     <= coff_in;
      pend_off_ff <= coff_ff;
      if (emit) begin
         rsp_tdata_ff <= byte_sel;
         rsp_tlast_ff <= (state_ff == S_SUM);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff  <= DEVICE_ID_RESET;
         model_low_ff  <= 8'd0;
         model_high_ff <= 8'd0;
         fw_version_ff <= 8'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEVICE_ID:  device_id_ff  <= csr_wdata;
            CSR_MODEL_LOW:  model_low_ff  <= csr_wdata;
            CSR_MODEL_HIGH: model_high_ff <= csr_wdata;
            CSR_FW_VERSION: fw_version_ff <= csr_wdata;
            default:        device_id_ff  <= device_id_ff;
         endcase
      end
   end

   // staging ram: written per write beat, read by the commit pass
   always_ff @(posedge clock) begin
      if (stg_we) begin
         stage_mem[stg_off] <= f_data;
      end
      stq_ff <= stage_mem[coff_ff];
   end

   // writable table
   sbrs_regfile #(
      .DEPTH        (DEPTH),
      .DFLT_LINK    (DEFAULT_LINK_TIMEOUT),
      .DFLT_SEND    (DEFAULT_SEND_TIMEOUT),
      .DFLT_RECEIVE (DEFAULT_RECEIVE_TIMEOUT)
   ) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (pend_ff),
      .wr_off  (pend_off_ff),
      .wr_data (stq_ff),
      .rd_off  (rd_off),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // checks
   a_commit_write_follows_pass: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == S_COMMIT))
      else $error("table write outside commit pass");

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DATA) |-> (n_ff != '0))
      else $error("data state with no bytes left");

   a_commit_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |-> (ccnt_ff != '0))
      else $error("commit pass with no bytes left");

   a_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      (br_ff != 8'd0) |-> (br_ff < wtotal_ff))
      else $error("write beat count beyond frame");

   a_header_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HDR) |-> (hcnt_ff <= HDR_ERR))
      else $error("header index out of range");

endmodule

/* dv/sbrs_status_checker.sv */
// sbrs_status_checker: tracks the register table, predicts status packets and compares beats
// depends on sbrs_pkg; instantiated beside servo_bus_register_slave_core in its testbench
`timescale 1ns / 100ps

module sbrs_status_checker
   import sbrs_pkg::*;
#(
   parameter int REG_COUNT               = 16,
   parameter int FIRST_WRITABLE          = 4,
   parameter int RANGE_ERROR_CODE        = 8,
   parameter int DEFAULT_LINK_TIMEOUT    = 0,
   parameter int DEFAULT_SEND_TIMEOUT    = 0,
   parameter int DEFAULT_RECEIVE_TIMEOUT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // start_addr [7:0], count [15:8], data_byte [23:16]
   input  logic        req_tuser,   // action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // out_byte [7:0]
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          mismatch_count,
   output int          beats_pending
);

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } status_beat_type;

   // expected status beats, oldest first
   status_beat_type status_q[$];
   status_beat_type want;

   // shadow of the configuration and the table
   logic [7:0] cfg_device_id;
   logic [7:0] cfg_model_low;
   logic [7:0] cfg_model_high;
   logic [7:0] cfg_fw_version;
   logic [7:0] reg_table [REG_COUNT];
   logic [7:0] staged    [REG_COUNT];

   // write in progress
   logic [7:0] bytes_seen;
   logic [7:0] wr_start;
   logic [7:0] wr_total;

   // table byte as seen by a read
   function automatic logic [7:0] table_byte(int addr);
      logic [7:0] b;
      if (addr >= REG_COUNT) begin
         b = 8'd0;
      end else if (addr >= FIRST_WRITABLE) begin
         b = reg_table[addr];
      end else begin
         case (addr)
            ADDR_MODEL_LOW:  b = cfg_model_low;
            ADDR_MODEL_HIGH: b = cfg_model_high;
            ADDR_FW_VERSION: b = cfg_fw_version;
            ADDR_DEVICE_ID:  b = cfg_device_id;
            default:         b = 8'd0;
         endcase
      end
      return b;
   endfunction

   // status packet: sync, sync, id, len, err, data..., checksum
   task automatic queue_status(input logic [7:0] err, input int addr, input int n);
      int         sum;
      logic [7:0] b;
      sum = int'(cfg_device_id) + int'(STATUS_BASE_LEN) + n + int'(err);
      status_q.push_back('{value: SYNC_BYTE, last: 1'b0});
      status_q.push_back('{value: SYNC_BYTE, last: 1'b0});
      status_q.push_back('{value: cfg_device_id, last: 1'b0});
      status_q.push_back('{value: 8'(int'(STATUS_BASE_LEN) + n), last: 1'b0});
      status_q.push_back('{value: err, last: 1'b0});
      for (int i = 0; i < n; i++) begin
         b = table_byte(addr + i);
         sum += int'(b);
         status_q.push_back('{value: b, last: 1'b0});
      end
      status_q.push_back('{value: 8'(255 - (sum % 256)), last: 1'b1});
   endtask

   // one request beat: reads answer at once, writes answer after their last byte
   task automatic predict_request(input logic action, input logic [7:0] start,
                                  input logic [7:0] count, input logic [7:0] data);
      int a;
      int off;
      bit ok;
      if (action == ACTION_READ) begin
         if (count == 0 || int'(start) + int'(count) > REG_COUNT)
            queue_status(8'(RANGE_ERROR_CODE), 0, 0);
         else
            queue_status(NO_ERROR, int'(start), int'(count));
         return;
      end
      // first byte latches the span; an empty write fails at once
      if (bytes_seen == 0) begin
         wr_start = start;
         wr_total = count;
         if (count == 0) begin
            queue_status(8'(RANGE_ERROR_CODE), 0, 0);
            return;
         end
      end
      a = int'(wr_start) + int'(bytes_seen);
      if (a >= FIRST_WRITABLE && a < REG_COUNT)
         staged[a] = data;
      bytes_seen = bytes_seen + 8'd1;
      if (bytes_seen < wr_total)
         return;
      // last byte: check span and bounds, then commit all or nothing
      bytes_seen = 8'd0;
      ok = int'(wr_start) >= FIRST_WRITABLE && int'(wr_start) + int'(wr_total) <= REG_COUNT;
      if (ok) begin
         for (int i = 0; i < int'(wr_total); i++) begin
            off = int'(wr_start) - FIRST_WRITABLE + i;
            if (off < BOUNDED_COUNT &&
                (staged[int'(wr_start) + i] < BOUND_LO || staged[int'(wr_start) + i] > BOUND_HI))
               ok = 1'b0;
         end
      end
      if (!ok) begin
         queue_status(8'(RANGE_ERROR_CODE), 0, 0);
      end else begin
         for (int i = 0; i < int'(wr_total); i++)
            reg_table[int'(wr_start) + i] = staged[int'(wr_start) + i];
         queue_status(NO_ERROR, 0, 0);
      end
   endtask

   // track configuration and requests, compare response beats
   always @(posedge clock) begin
      if (reset) begin
         cfg_device_id  = DEVICE_ID_RESET;
         cfg_model_low  = 8'd0;
         cfg_model_high = 8'd0;
         cfg_fw_version = 8'd0;
         for (int i = 0; i < REG_COUNT; i++) begin
            reg_table[i] = 8'd0;
            staged[i]    = 8'd0;
         end
         reg_table[FIRST_WRITABLE]     = 8'(DEFAULT_LINK_TIMEOUT);
         reg_table[FIRST_WRITABLE + 1] = 8'(DEFAULT_SEND_TIMEOUT);
         reg_table[FIRST_WRITABLE + 2] = 8'(DEFAULT_RECEIVE_TIMEOUT);
         bytes_seen     = 8'd0;
         wr_start       = 8'd0;
         wr_total       = 8'd0;
         mismatch_count = 0;
         status_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DEVICE_ID:  cfg_device_id  = csr_wdata;
               CSR_MODEL_LOW:  cfg_model_low  = csr_wdata;
               CSR_MODEL_HIGH: cfg_model_high = csr_wdata;
               CSR_FW_VERSION: cfg_fw_version = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_request(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               $error("unexpected status beat: out_byte %0h last_byte %0b", rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = status_q.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("out_byte: expected %0h, actual %0h", want.value, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_byte: expected %0b, actual %0b", want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
      end
      beats_pending = status_q.size();
   end

endmodule

/* dv/servo_bus_register_slave_core_tb.sv */
// servo_bus_register_slave_core_tb: drives read and write requests and csr settings
// depends on sbrs_pkg, servo_bus_register_slave_core and sbrs_status_checker
`timescale 1ns / 100ps

module servo_bus_register_slave_core_tb;
   import sbrs_pkg::*;

   localparam int REG_COUNT        = 16;
   localparam int FIRST_WRITABLE   = 4;
   localparam int RANGE_ERROR_CODE = 8;
   localparam int DRAIN_CYCLES     = 64;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // start_addr [7:0], count [15:8], data_byte [23:16]
   logic        req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // out_byte [7:0]
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   int          fail_count;
   int          beats_pending;
   int          items_sent;
   bit          quiet;

   servo_bus_register_slave_core #(
      .REG_COUNT        (REG_COUNT),
      .FIRST_WRITABLE   (FIRST_WRITABLE),
      .RANGE_ERROR_CODE (RANGE_ERROR_CODE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sbrs_status_checker #(
      .REG_COUNT        (REG_COUNT),
      .FIRST_WRITABLE   (FIRST_WRITABLE),
      .RANGE_ERROR_CODE (RANGE_ERROR_CODE)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (fail_count),
      .beats_pending  (beats_pending)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

   // response side: random ready and stall runs, always ready when quiet
   initial begin : rsp_backpressure
      int run_left;
      bit run_ready;
      run_left   = 0;
      run_ready  = 1'b1;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            if (run_left == 0) begin
               run_ready = $urandom_range(0, 2) != 0;
               run_left  = $urandom_range(1, 16);
            end
            rsp_tready <= run_ready;
            run_left--;
         end
      end
   end

   // one request beat, with an optional idle gap ahead of it
   task automatic send_item(input logic action, input logic [7:0] start,
                            input logic [7:0] count, input logic [7:0] data);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {data, count, start};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // read inside the table
   task automatic send_good_read();
      logic [7:0] start;
      start = 8'($urandom_range(0, REG_COUNT - 1));
      send_item(ACTION_READ, start, 8'($urandom_range(1, REG_COUNT - start)),
                8'($urandom_range(0, 255)));
   endtask

   // complete write; bounded entries mostly get legal bytes, reads may slip in between
   task automatic send_write(input logic [7:0] start, input logic [7:0] count);
      logic [7:0] b;
      int         off;
      for (int i = 0; i < int'(count); i++) begin
         off = int'(start) + i - FIRST_WRITABLE;
         if (off >= 0 && off < BOUNDED_COUNT && $urandom_range(0, 9) != 0)
            b = 8'($urandom_range(BOUND_LO, BOUND_HI));
         else
            b = 8'($urandom_range(0, 255));
         if (i > 0 && $urandom_range(0, 7) == 0)
            send_good_read();
         if (i == 0)
            send_item(ACTION_WRITE, start, count, b);
         else
            send_item(ACTION_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), b);
      end
   endtask

   // one random transaction: mostly well-formed, some noise and broken writes
   task automatic random_txn();
      int         pick;
      logic [7:0] start;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         send_good_read();
      end else if (pick < 75) begin
         start = 8'($urandom_range(FIRST_WRITABLE, REG_COUNT - 1));
         send_write(start, 8'($urandom_range(1, REG_COUNT - start)));
      end else if (pick < 85) begin
         send_item(ACTION_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
         send_item(ACTION_WRITE, 8'($urandom_range(0, 255)), 8'd0, 8'($urandom_range(0, 255)));
      end else begin
         send_write(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)));
      end
   endtask

   task automatic run_random(input int n_items);
      int target;
      target = items_sent + n_items;
      while (items_sent < target)
         random_txn();
   endtask

   // wait out every expected beat plus a margin for a trailing copy pass
   task automatic settle();
      req_tvalid <= 1'b0;
      while (beats_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] dev_id, input logic [7:0] m_low,
                             input logic [7:0] m_high, input logic [7:0] fw);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEVICE_ID;
      csr_wdata <= dev_id;
      @(negedge clock);
      csr_index <= CSR_MODEL_LOW;
      csr_wdata <= m_low;
      @(negedge clock);
      csr_index <= CSR_MODEL_HIGH;
      csr_wdata <= m_high;
      @(negedge clock);
      csr_index <= CSR_FW_VERSION;
      csr_wdata <= fw;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACTION_READ;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_DEVICE_ID;
      csr_wdata  = 8'd0;
      items_sent = 0;
      quiet      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reads at reset values and range limits
      send_item(ACTION_READ, 8'd0, 8'd16, 8'd0);
      send_item(ACTION_READ, 8'd0, 8'd0, 8'd0);
      send_item(ACTION_READ, 8'd15, 8'd1, 8'd0);
      send_item(ACTION_READ, 8'd15, 8'd2, 8'd0);
      send_item(ACTION_READ, 8'd255, 8'd255, 8'hff);
      send_item(ACTION_READ, 8'd0, 8'd255, 8'd0);
      // empty write drops its byte
      send_item(ACTION_WRITE, 8'd4, 8'd0, 8'hff);
      // bounded entries at their limits
      send_item(ACTION_WRITE, 8'd4, 8'd3, BOUND_LO);
      send_item(ACTION_WRITE, 8'd0, 8'd0, BOUND_HI);
      send_item(ACTION_WRITE, 8'd0, 8'd0, 8'd128);
      send_item(ACTION_READ, 8'd4, 8'd3, 8'd0);
      // just outside the bounds
      send_item(ACTION_WRITE, 8'd4, 8'd1, 8'd9);
      send_item(ACTION_WRITE, 8'd6, 8'd1, 8'd255);
      // start in the read-only part
      send_item(ACTION_WRITE, 8'd3, 8'd2, 8'h55);
      send_item(ACTION_WRITE, 8'd0, 8'd0, 8'haa);
      // span past the end, last byte never staged
      send_item(ACTION_WRITE, 8'd14, 8'd3, 8'd1);
      send_item(ACTION_WRITE, 8'd0, 8'd0, 8'd2);
      send_item(ACTION_WRITE, 8'd0, 8'd0, 8'd3);
      // unbounded entries take the full byte range
      send_item(ACTION_WRITE, 8'd7, 8'd1, 8'd0);
      send_item(ACTION_WRITE, 8'd15, 8'd1, 8'd255);
      // read in the middle of a write, later byte carries junk span fields
      send_item(ACTION_WRITE, 8'd8, 8'd2, 8'h12);
      send_item(ACTION_READ, 8'd0, 8'd16, 8'd0);
      send_item(ACTION_WRITE, 8'hff, 8'hff, 8'h34);
      send_item(ACTION_READ, 8'd0, 8'd16, 8'd0);

      run_random(20);
      settle();

      // low id, all-ones read-only bytes
      set_config(8'd0, 8'd255, 8'd255, 8'd255);
      run_random(20);
      settle();

      // random settings
      set_config(8'($urandom_range(1, 252)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random(15);
      settle();

      // highest id, no idling from here on
      set_config(8'd253, 8'd0, 8'd0, 8'd0);
      quiet = 1'b1;
      run_random(15);
      settle();

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* servo_bus_register_slave_core.f */
hdl/sbrs_pkg.sv
hdl/sbrs_regfile.sv
hdl/servo_bus_register_slave_core.sv
dv/sbrs_status_checker.sv
dv/servo_bus_register_slave_core_tb.sv
